### rtl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
	localparam int HeapBytes = 65536;
	localparam int SizeAlign = 16;
	localparam int MinBlockBytes = 32;
	localparam int HeaderBytes = 40;
	localparam int GranuleBytes = 8;
	localparam int NumGranules = HeapBytes / GranuleBytes;
	localparam int GW = $clog2(NumGranules);
	localparam int HW = $clog2(HeapBytes) + 2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;
	localparam logic [2:0] ST_OOM = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_DOUBLE = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_AREAD, S_AWAIT, S_ACHECK, S_FREAD, S_FWAIT, S_FCHECK,
		S_NREAD, S_NWAIT, S_NMERGE, S_PREAD, S_PWAIT, S_PCHECK, S_DONE
	} state_t;

	// memory port request
	typedef struct packed {
		logic          we;
		logic [GW-1:0] waddr;
		logic          wstart;
		logic          wuse;
		logic [16:0]   wsize;
		logic [GW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic        start;
		logic        use_b;
		logic [16:0] size;
	} mem_rd_t;
endpackage
`default_nettype wire

### rtl/ffha_table.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_table
	import ffha_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output mem_rd_t       rd
);
	// start, in use and size per granule; cleared by a sweep from the core
	logic [18:0] mem [NumGranules];
	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= {req.wstart, req.wuse, req.wsize};
		rd <= mem[req.raddr];
	end
endmodule
`default_nettype wire

### rtl/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// first-fit heap allocator with coalescing, one request at a time
// alloc walks the blocks from the heap start; free reads its block, merges the next
// one and scans back granule by granule to the previous block start (one table read port)
// errors end early: zero size or bad offset, and double free
// after reset a clearing pass over all 8192 granules runs with busy high
// results are one-cycle strobes; the receiver cannot stall
`default_nettype none
module first_fit_heap_allocator_core
	import ffha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [15:0] request_size,
	input  wire logic [15:0] free_offset,
	output logic             done,
	output logic [2:0]       status,
	output logic [15:0]      block_offset,
	output logic [15:0]      granted_size,
	output logic [15:0]      used_bytes,
	output logic [15:0]      free_bytes
);
	state_t state_q, state_d;
	mem_req_t req;
	mem_req_t wreq2;
	mem_rd_t rd;
	logic [GW-1:0] clr_q, g_q, k_q;
	logic [HW-1:0] h_q;
	logic [16:0] need_q, sz_q, used_q;
	logic [2:0] st_q;
	logic [15:0] off_q, gsz_q;
	logic [HW-1:0] nh;
	logic [HW-1:0] fhdr;
	logic free_bad;
	logic [17:0] rnd;
	logic [17:0] sum;

	// header after the current block, held for the next-merge read
	logic [HW-1:0] nxt_h_q;
	logic nxt_valid_q;
	logic nxt_ok;
	logic split_ok;
	logic [HW-1:0] split_h;
	logic alloc_hit;
	logic prev_hit;
	logic pend_set;

	// second write for split, next-merge clear and prev-merge clear happens in a follow-up cycle
	logic pend_q;
	logic [GW-1:0] pend_a_q;
	logic pend_start_q;
	logic [16:0] pend_sz_q;

	ffha_table u_tab (.clk(clk), .req(wreq2), .rd(rd));

	// combinational helpers: next header, merged size, rounded request size and free header check
	always_comb begin
		nh = h_q + HW'(HeaderBytes) + HW'(rd.size);
		sum = 18'(sz_q) + 18'(HeaderBytes) + 18'(rd.size);
		rnd = ((18'(request_size) + 18'(SizeAlign - 1)) >> $clog2(SizeAlign))
			<< $clog2(SizeAlign);
		fhdr = HW'(free_offset) - HW'(HeaderBytes);
		free_bad = (free_offset < 16'(HeaderBytes)) || ((fhdr % GranuleBytes) != 0);
	end

	assign split_h = h_q + HW'(HeaderBytes) + HW'(need_q);
	assign split_ok = split_h < HW'(HeapBytes);
	assign nxt_ok = nxt_valid_q && rd.start && !rd.use_b;
	assign alloc_hit = (state_q == S_ACHECK) && !rd.use_b && rd.size >= need_q;
	assign prev_hit = (state_q == S_PCHECK) && rd.start && !rd.use_b;
	assign pend_set = (alloc_hit && req.wsize != rd.size)
		|| (state_q == S_NMERGE && nxt_ok) || prev_hit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = operation ? S_FREAD : S_AREAD;
			S_CLEAR: if (clr_q == GW'(NumGranules - 1)) state_d = S_IDLE;
			S_AREAD: state_d = (st_q != ST_OK) ? S_DONE : S_AWAIT;
			S_AWAIT: state_d = S_ACHECK;
			S_ACHECK: begin
				if (!rd.use_b && rd.size >= need_q) state_d = S_DONE;
				else if (nh >= HW'(HeapBytes)) state_d = S_DONE;
				else state_d = S_AREAD;
			end
			S_FREAD: state_d = (st_q != ST_OK) ? S_DONE : S_FWAIT;
			S_FWAIT: state_d = S_FCHECK;
			S_FCHECK: state_d = (!rd.start || !rd.use_b) ? S_DONE : S_NREAD;
			S_NREAD: state_d = S_NWAIT;
			S_NWAIT: state_d = S_NMERGE;
			S_NMERGE: state_d = (g_q == '0) ? S_DONE : S_PREAD;
			S_PREAD: state_d = S_PWAIT;
			S_PWAIT: state_d = S_PCHECK;
			S_PCHECK: state_d = (rd.start || k_q == '0) ? S_DONE : S_PREAD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// table port; the address held in a wait state is the one checked next
	always_comb begin
		req = '0;
		req.raddr = g_q;
		unique case (state_q)
			S_CLEAR: begin
				req.we = 1'b1;
				req.waddr = clr_q;
				req.wstart = (clr_q == '0);
				req.wsize = (clr_q == '0) ? 17'(HeapBytes - HeaderBytes) : '0;
			end
			S_NREAD, S_NWAIT: req.raddr = GW'(nxt_h_q / GranuleBytes);
			S_PREAD, S_PWAIT: req.raddr = k_q;
			default: ;
		endcase
		if (alloc_hit) begin
			req.we = 1'b1;
			req.waddr = g_q;
			req.wstart = 1'b1;
			req.wuse = 1'b1;
			req.wsize = rd.size;
			if (rd.size >= need_q + 17'(HeaderBytes + MinBlockBytes)
				&& split_ok) req.wsize = need_q;
		end
		if (state_q == S_FCHECK && rd.start && rd.use_b) begin
			req.we = 1'b1;
			req.waddr = g_q;
			req.wstart = 1'b1;
			req.wsize = rd.size;
		end
		if (state_q == S_NMERGE) begin
			req.we = 1'b1;
			req.waddr = g_q;
			req.wstart = 1'b1;
			req.wsize = sz_q;
			if (nxt_ok) req.wsize = sum[16:0];
		end
		if (prev_hit) begin
			req.we = 1'b1;
			req.waddr = k_q;
			req.wstart = 1'b1;
			req.wsize = sum[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			used_q <= '0;
			pend_q <= 1'b0;
			h_q <= '0;
			g_q <= '0;
			k_q <= '0;
			need_q <= '0;
			sz_q <= '0;
			st_q <= ST_OK;
			off_q <= '0;
			gsz_q <= '0;
			nxt_h_q <= '0;
			nxt_valid_q <= 1'b0;
			pend_a_q <= '0;
			pend_start_q <= 1'b0;
			pend_sz_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			pend_q <= pend_set;
			unique case (state_q)
				S_IDLE: if (start) begin
					off_q <= '0;
					gsz_q <= '0;
					if (operation) begin
						h_q <= fhdr;
						g_q <= GW'(fhdr / GranuleBytes);
						k_q <= GW'(fhdr / GranuleBytes);
						st_q <= free_bad ? ST_INVALID : ST_OK;
					end else begin
						h_q <= '0;
						g_q <= '0;
						st_q <= (request_size == '0) ? ST_ZERO : ST_OK;
						need_q <= (rnd < 18'(MinBlockBytes)) ? 17'(MinBlockBytes)
							: rnd[16:0];
					end
				end
				S_ACHECK: begin
					if (alloc_hit) begin
						sz_q <= req.wsize;
						used_q <= used_q + req.wsize;
						off_q <= 16'(h_q + HW'(HeaderBytes));
						gsz_q <= req.wsize[15:0];
						if (req.wsize != rd.size) begin
							pend_a_q <= GW'(split_h / GranuleBytes);
							pend_start_q <= 1'b1;
							pend_sz_q <= rd.size - need_q - 17'(HeaderBytes);
						end
					end else if (nh >= HW'(HeapBytes)) begin
						st_q <= ST_OOM;
					end else begin
						h_q <= nh;
						g_q <= GW'(nh / GranuleBytes);
					end
				end
				S_FCHECK: begin
					if (!rd.start) st_q <= ST_INVALID;
					else if (!rd.use_b) st_q <= ST_DOUBLE;
					else begin
						sz_q <= rd.size;
						gsz_q <= rd.size[15:0];
						used_q <= used_q - rd.size;
						nxt_h_q <= nh;
						nxt_valid_q <= nh < HW'(HeapBytes);
					end
				end
				S_NMERGE: begin
					sz_q <= req.wsize;
					if (nxt_ok) begin
						pend_a_q <= GW'(nxt_h_q / GranuleBytes);
						pend_start_q <= 1'b0;
						pend_sz_q <= '0;
					end
				end
				S_PREAD: k_q <= k_q - 1'b1;
				S_PCHECK: if (prev_hit) begin
					pend_a_q <= g_q;
					pend_start_q <= 1'b0;
					pend_sz_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// pending writes land in the cycle after ACHECK, NMERGE or PCHECK,
	// which is a read or done cycle with no other write
	always_comb begin
		wreq2 = req;
		if (pend_q) begin
			wreq2.we = 1'b1;
			wreq2.waddr = pend_a_q;
			wreq2.wstart = pend_start_q;
			wreq2.wuse = 1'b0;
			wreq2.wsize = pend_sz_q;
		end
	end

	assign busy = (state_q != S_IDLE);
	always_comb begin
		done = (state_q == S_DONE);
		status = st_q;
		block_offset = (st_q == ST_OK) ? off_q : '0;
		granted_size = (st_q == ST_OK) ? gsz_q : '0;
		used_bytes = used_q[15:0];
		free_bytes = 16'(17'(HeapBytes) - used_q - 17'(HeaderBytes));
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("double strobe");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept without busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside work");
endmodule
`default_nettype wire
